FILE: hw/rtl/dti_pkg.sv
// Shared types and constants for the drag table interpolator.
`default_nettype none

package dti_pkg;

  localparam int MACH_W = 16;
  localparam int COEF_W = 16;
  localparam int INDEX_W = 7;
  localparam int LEN_W = 8;
  localparam int PROD_W = MACH_W + COEF_W;
  localparam int IN_DATA_W = 56;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [MACH_W-1:0] mach;
    logic [COEF_W-1:0] coef;
  } point_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dti_cell.sv
// One table cell: holds a point, loads it by index and hands it to its neighbor on shift.
`default_nettype none

module dti_cell (
  input  wire logic            clk,
  input  wire dti_pkg::cell_ctl_t ctl,
  input  wire dti_pkg::point_t wdata,
  input  wire dti_pkg::point_t nbr,
  output dti_pkg::point_t      pt
);

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      pt <= wdata;
    end else if (ctl.shift) begin
      pt <= nbr;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dti_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module dti_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [dti_pkg::PROD_W-1:0]   dividend,
  input  wire logic [dti_pkg::MACH_W-1:0]   divisor,
  output logic                              done,
  output logic [dti_pkg::PROD_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(dti_pkg::PROD_W + 1);

  logic                         busy;
  logic [CNT_W-1:0]             count;
  logic [dti_pkg::MACH_W:0]     rem;
  logic [dti_pkg::MACH_W-1:0]   dsr;
  logic [dti_pkg::MACH_W:0]     rem_sh;
  logic                         fits;

  assign rem_sh = {rem[dti_pkg::MACH_W-1:0], quotient[dti_pkg::PROD_W-1]};
  assign fits = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CNT_W'(dti_pkg::PROD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
      quotient <= {quotient[dti_pkg::PROD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/drag_table_interpolator_unit.sv
// Top level: drag coefficient lookup over a rotating ring of table cells.
//
//  channel  | direction | words
//  s_axis   | in        | loads (tuser 0) and queries (tuser 1)
//  m_axis   | out       | one interpolated coefficient per query
//  cfg      | in        | table_length write
//
//  A load is written into its cell as it is taken. A query on a table of zero or one point
//  goes straight to the result. Otherwise the ring rotates one full turn past the head compare,
//  then an evaluate step follows; a query outside every segment or on a zero-width one ends there,
//  an interpolated one adds a divider start step, the divider run and the hand-off to the output.
//  rst clears control state and table_length; table contents are undefined until loaded.
//  A stalled m_axis holds the result; new words are taken once the result is registered.
`default_nettype none

module drag_table_interpolator_unit #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [6:0] entry_index, [22:7] entry_mach, [38:23] entry_coefficient, [54:39] query_mach
  input  wire logic [55:0] s_axis_tdata,
  // [0] req_type
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] drag_coefficient
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > dti_pkg::LEN_W) ? CW : dti_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EVAL, S_DIVST, S_DIV, S_DONE
  } state_t;

  state_t state;

  logic [dti_pkg::LEN_W-1:0]  table_length;
  logic [NW-1:0]              n_use;
  logic [NW-1:0]              step;
  logic [dti_pkg::MACH_W-1:0] q;
  logic                       found;
  dti_pkg::point_t            seg_a;
  dti_pkg::point_t            seg_b;
  logic [dti_pkg::COEF_W-1:0] c_last;
  logic [dti_pkg::COEF_W-1:0] res;
  logic [dti_pkg::PROD_W-1:0] prod;
  logic                       neg;

  dti_pkg::point_t            pts [TABLE_DEPTH];
  dti_pkg::point_t            wpt;
  logic                       in_fire;
  logic                       load_fire;
  logic [dti_pkg::INDEX_W-1:0] load_idx;
  logic [dti_pkg::MACH_W-1:0] q_in;
  logic                       hit;
  logic [dti_pkg::COEF_W:0]   dc;
  logic [dti_pkg::COEF_W-1:0] dc_mag;
  logic [dti_pkg::MACH_W-1:0] dq;
  logic [dti_pkg::MACH_W-1:0] den;
  logic                       div_done;
  logic [dti_pkg::PROD_W-1:0] quot;
  logic [dti_pkg::COEF_W-1:0] qmag;

  assign s_axis_tready = !rst && (state == S_IDLE);
  assign cfg_ready = !rst;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign load_fire = in_fire && (s_axis_tuser[0] == dti_pkg::REQ_LOAD);
  assign load_idx = s_axis_tdata[6:0];
  assign wpt.mach = s_axis_tdata[22:7];
  assign wpt.coef = s_axis_tdata[38:23];
  assign q_in = s_axis_tdata[54:39];

  assign n_use = (NW'(table_length) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                        : NW'(table_length);

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    dti_pkg::cell_ctl_t ctl;
    assign ctl.shift = (state == S_SCAN);
    assign ctl.write = load_fire && (32'(load_idx) == k);
    dti_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .wdata (wpt),
      .nbr   (pts[(k + 1) % TABLE_DEPTH]),
      .pt    (pts[k])
    );
  end

  assign hit = !found && (step < n_use - 1'b1) &&
               (q >= pts[0].mach) && (q <= pts[1].mach);

  assign dc = {1'b0, seg_b.coef} - {1'b0, seg_a.coef};
  assign dc_mag = dc[dti_pkg::COEF_W] ? dti_pkg::COEF_W'(-dc) : dc[dti_pkg::COEF_W-1:0];
  assign dq = q - seg_a.mach;
  assign den = seg_b.mach - seg_a.mach;
  assign qmag = quot[dti_pkg::COEF_W-1:0];

  dti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVST),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      table_length <= '0;
      m_axis_tvalid <= 1'b0;
      step <= '0;
      found <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        table_length <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && s_axis_tuser[0] == dti_pkg::REQ_QUERY) begin
            q <= q_in;
            step <= '0;
            found <= 1'b0;
            if (n_use == '0) begin
              res <= '0;
              state <= S_DONE;
            end else if (n_use == NW'(1)) begin
              res <= pts[0].coef;
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            seg_a <= pts[0];
            seg_b <= pts[1];
          end
          if (step == n_use - 1'b1) begin
            c_last <= pts[0].coef;
          end
          step <= step + 1'b1;
          if (step == NW'(TABLE_DEPTH - 1)) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!found) begin
            res <= (q < pts[0].mach) ? pts[0].coef : c_last;
            state <= S_DONE;
          end else if (den == '0) begin
            res <= seg_a.coef;
            state <= S_DONE;
          end else begin
            prod <= dti_pkg::PROD_W'(dq) * dti_pkg::PROD_W'(dc_mag);
            neg <= dc[dti_pkg::COEF_W];
            state <= S_DIVST;
          end
        end
        S_DIVST: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res <= neg ? (seg_a.coef - qmag) : (seg_a.coef + qmag);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= res;
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_seg_holds_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && found) |-> (q >= seg_a.mach && q <= seg_b.mach))
    else $error("latched segment does not contain the query");

  a_ring_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (step == NW'(TABLE_DEPTH)))
    else $error("ring not rotated back to its home position");

  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (quot[dti_pkg::PROD_W-1:dti_pkg::COEF_W] == '0))
    else $error("interpolation quotient exceeds coefficient width");

  a_div_only_when_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVST) |-> (found && den != '0))
    else $error("divider started without a valid segment");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Testbench for drag_table_interpolator_unit: table loads, length settings and checked lookups.
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH = 128;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 2000;
  localparam int RANDOM_ITEMS = 800;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [dti_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]                    s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [dti_pkg::COEF_W-1:0]    m_axis_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dti_pkg::LEN_W-1:0]     cfg_data = '0;

  logic [dti_pkg::MACH_W-1:0] mach_tab [TABLE_DEPTH];
  logic [dti_pkg::COEF_W-1:0] coef_tab [TABLE_DEPTH];
  logic [dti_pkg::LEN_W-1:0]  length_reg = '0;
  logic [dti_pkg::COEF_W-1:0] expected_coef [$];

  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  logic        hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_done = 0;

  always #6 clk = ~clk;

  drag_table_interpolator_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    // [6:0] entry_index, [22:7] entry_mach, [38:23] entry_coefficient, [54:39] query_mach
    .s_axis_tdata(s_axis_tdata),
    // [0] req_type
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    // [15:0] drag_coefficient
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic int unsigned points_in_use();
    return (32'(length_reg) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(length_reg);
  endfunction

  function automatic logic [dti_pkg::COEF_W-1:0] interpolate_drag(
      input logic [dti_pkg::MACH_W-1:0] q);
    int unsigned n;
    longint num;
    longint den;
    longint term;
    n = points_in_use();
    if (n == 0) return '0;
    if (n == 1) return coef_tab[0];
    for (int i = 0; i + 1 < n; i++) begin
      if (q >= mach_tab[i] && q <= mach_tab[i+1]) begin
        if (mach_tab[i] == mach_tab[i+1]) return coef_tab[i];
        num = (longint'(q) - longint'(mach_tab[i]))
            * (longint'(coef_tab[i+1]) - longint'(coef_tab[i]));
        den = longint'(mach_tab[i+1]) - longint'(mach_tab[i]);
        term = num / den;
        return dti_pkg::COEF_W'(longint'(coef_tab[i]) + term);
      end
    end
    if (q < mach_tab[0]) return coef_tab[0];
    return coef_tab[n-1];
  endfunction

  function automatic int unsigned idle_span(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [dti_pkg::COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return dti_pkg::COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [dti_pkg::MACH_W-1:0] pick_query_mach();
    int unsigned n;
    int unsigned k;
    n = points_in_use();
    if (n == 0) return dti_pkg::MACH_W'($urandom);
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 5))
      0: return dti_pkg::MACH_W'($urandom);
      1: return mach_tab[k];
      2: return mach_tab[k] + dti_pkg::MACH_W'($urandom_range(0, 4)) - dti_pkg::MACH_W'(2);
      3: return (mach_tab[0] == 0) ? '0 :
                dti_pkg::MACH_W'($urandom_range(0, mach_tab[0] - 1));
      4: return (mach_tab[n-1] == '1) ? '1 :
                dti_pkg::MACH_W'($urandom_range(mach_tab[n-1] + 1, 16'hFFFF));
      default: return dti_pkg::MACH_W'($urandom_range(mach_tab[k],
                                       mach_tab[(k + 1 < n) ? k + 1 : k]));
    endcase
  endfunction

  task automatic note_failure(input string what, input logic [dti_pkg::COEF_W-1:0] want,
                              input logic [dti_pkg::COEF_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic send_word(input logic req, input logic [dti_pkg::INDEX_W-1:0] idx,
                           input logic [dti_pkg::MACH_W-1:0] mach,
                           input logic [dti_pkg::COEF_W-1:0] coef,
                           input logic [dti_pkg::MACH_W-1:0] qmach);
    int unsigned gap;
    gap = idle_span(gaps_on);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {1'b0, qmach, coef, mach, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (req == dti_pkg::REQ_LOAD) begin
      mach_tab[idx] = mach;
      coef_tab[idx] = coef;
      loads_sent++;
    end else begin
      expected_coef.push_back(interpolate_drag(qmach));
      queries_sent++;
    end
  endtask

  task automatic send_query(input logic [dti_pkg::MACH_W-1:0] qmach);
    send_word(dti_pkg::REQ_QUERY, dti_pkg::INDEX_W'($urandom), dti_pkg::MACH_W'($urandom),
              dti_pkg::COEF_W'($urandom), qmach);
  endtask

  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (expected_coef.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_length(input logic [dti_pkg::LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    length_reg = len;
    settings_done++;
  endtask

  task automatic load_table(input int unsigned n_pts, input bit ascending);
    int unsigned m;
    int unsigned step_max;
    m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16'h2000);
    step_max = (n_pts > 1) ? (16'hFFFF - m) / (n_pts - 1) : 0;
    for (int i = 0; i < n_pts; i++) begin
      send_word(dti_pkg::REQ_LOAD, dti_pkg::INDEX_W'(i),
                ascending ? dti_pkg::MACH_W'(m) : dti_pkg::MACH_W'($urandom),
                pick_coef(), dti_pkg::MACH_W'($urandom));
      if ($urandom_range(0, 9) != 0) m = m + $urandom_range(0, step_max);
    end
  endtask

  task automatic test_empty_table();
    send_query('0);
    send_query('1);
  endtask

  task automatic test_single_point();
    send_word(dti_pkg::REQ_LOAD, '0, '0, 16'h3A5C, dti_pkg::MACH_W'($urandom));
    drain_block();
    write_table_length(dti_pkg::LEN_W'(1));
    send_query('0);
    send_query(16'h8000);
    send_query('1);
  endtask

  task automatic test_segment_cases();
    send_word(dti_pkg::REQ_LOAD, 7'd0, 16'h1000, 16'h0100, dti_pkg::MACH_W'($urandom));
    send_word(dti_pkg::REQ_LOAD, 7'd1, 16'h1000, 16'hFFFF, dti_pkg::MACH_W'($urandom));
    send_word(dti_pkg::REQ_LOAD, 7'd2, 16'h3000, 16'h0000, dti_pkg::MACH_W'($urandom));
    send_word(dti_pkg::REQ_LOAD, 7'd3, 16'hF000, 16'hFFFF, dti_pkg::MACH_W'($urandom));
    send_word(dti_pkg::REQ_LOAD, '1, '1, '1, '1);
    drain_block();
    write_table_length(dti_pkg::LEN_W'(4));
    send_query('0);
    send_query(16'h0800);
    send_query(16'h1000);
    send_query(16'h2001);
    send_query(16'h3000);
    send_query(16'h9000);
    send_query(16'hF000);
    send_query('1);
    drain_block();
  endtask

  task automatic test_output_hold();
    gaps_on = 1'b0;
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    repeat (12) send_query(pick_query_mach());
    drain_block();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_tables();
    int unsigned lengths [6] = '{128, 2, 255, 0, 1, 3};
    int unsigned start;
    int unsigned phase;
    int unsigned len;
    int unsigned n_queries;
    start = loads_sent + queries_sent;
    phase = 0;
    while (loads_sent + queries_sent - start < RANDOM_ITEMS) begin
      if (phase < 6) len = lengths[phase];
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(17, 64);
      else len = $urandom_range(2, 16);
      gaps_on = (phase % 4 == 0) || (phase % 4 == 2);
      stalls_on = (phase % 4 == 0) || (phase % 4 == 3);
      load_table((len > TABLE_DEPTH) ? TABLE_DEPTH : len, $urandom_range(0, 5) != 0);
      drain_block();
      write_table_length(dti_pkg::LEN_W'(len));
      n_queries = $urandom_range(15, 40);
      repeat (n_queries) begin
        if ($urandom_range(0, 7) == 0)
          send_word(dti_pkg::REQ_LOAD, dti_pkg::INDEX_W'($urandom),
                    dti_pkg::MACH_W'($urandom), pick_coef(), dti_pkg::MACH_W'($urandom));
        else
          send_query(pick_query_mach());
      end
      drain_block();
      phase++;
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_coef.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_request) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst || hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left <= idle_span(stalls_on);
    end
  end

  always @(posedge clk) begin : result_check
    logic [dti_pkg::COEF_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_coef.size() == 0) begin
        note_failure("result word with no query outstanding", 'x, m_axis_tdata);
      end else begin
        want = expected_coef.pop_front();
        if (m_axis_tdata !== want) note_failure("drag_coefficient mismatch", want, m_axis_tdata);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_single_point();
    test_segment_cases();
    test_output_hold();
    test_random_tables();
    drain_block();
    $display("Covered %0d loads and %0d queries (%0d results checked) over %0d length settings",
             loads_sent, queries_sent, results_checked, settings_done);
    $display("including empty, single point, full and oversized tables, %0d failures", fail_count);
    if (fail_count == 0 && expected_coef.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
